@@ hw/rtl/lpfd_pkg.sv @@
`timescale 1ns / 1ps

package lpfd_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int LIMIT_BITS  = 24;

  localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND = 8'h55;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1048576);

  localparam logic [1:0] ST_PAYLOAD  = 2'd0;
  localparam logic [1:0] ST_CRC_GOOD = 2'd1;
  localparam logic [1:0] ST_CRC_BAD  = 2'd2;
  localparam logic [1:0] ST_OVERSIZE = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data_byte;
    logic        is_last;
    logic [1:0]  status;
    logic [31:0] frame_length;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } lpfd_result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/length_prefixed_frame_deframer_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata[7:0]         received stream byte
// m_axis    out        tvalid tready tdata tlast tuser  payload byte or frame report
// cfg       in         cfg_valid cfg_ready cfg_data     max_payload_length
//
// One byte is taken every cycle unless the output stalls; a byte passes an input
// register, the parse and CRC logic and the output register that presents it.
// Synchronous reset returns the parser to header hunting and the limit to 1048576.
// A stalled output holds both registers and lowers s_axis_tready once the
// input register is full; cfg_ready is always high.

module length_prefixed_frame_deframer_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // rx_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [71:0]                     m_axis_tdata,   // data_byte, frame_length,
                                                          // computed_crc, received_crc
  output logic                            m_axis_tlast,   // is_last
  output logic [1:0]                      m_axis_tuser,   // status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpfd_pkg::LIMIT_BITS-1:0] cfg_data
);
  import lpfd_pkg::*;

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  advance;
  logic                  step;
  logic [LIMIT_BITS-1:0] max_len;
  lpfd_result_t          res;
  lpfd_result_t          out_reg;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LIMIT_RESET;
    end else if (cfg_valid) begin
      max_len <= cfg_data;
    end
  end

  lpfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .max_len (max_len),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_reg <= res;
    end
  end

  assign m_axis_tdata = {out_reg.received_crc, out_reg.computed_crc,
                         out_reg.frame_length, out_reg.data_byte};
  assign m_axis_tlast = out_reg.is_last;
  assign m_axis_tuser = out_reg.status;

endmodule

@@ hw/rtl/lpfd_parser.sv @@
`timescale 1ns / 1ps

module lpfd_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [7:0]                     rx_byte,
  input  logic [lpfd_pkg::LIMIT_BITS-1:0] max_len,
  output lpfd_pkg::lpfd_result_t         result
);
  import lpfd_pkg::*;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_SYNC   = 6'b000010,
    PH_LEN    = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_TRL_LO = 6'b010000,
    PH_TRL_HI = 6'b100000
  } phase_t;

  localparam logic [31:0] COUNT_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  phase_t                 phase, phase_next;
  logic [1:0]             field_idx, field_idx_next;
  logic [31:0]            declared, declared_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [15:0]            crc, crc_next;
  logic [7:0]             trl_lo, trl_lo_next;
  logic [31:0]            len_full;
  logic [15:0]            rx_crc;
  logic [LENGTH_BITS-1:0] rem_dec;

  assign len_full = declared | (32'(rx_byte) << {field_idx, 3'b000});
  assign rx_crc   = {rx_byte, trl_lo};
  assign rem_dec  = remaining - LENGTH_BITS'(1);

  always_comb begin
    phase_next     = phase;
    field_idx_next = field_idx;
    declared_next  = declared;
    remaining_next = remaining;
    crc_next       = crc;
    trl_lo_next    = trl_lo;
    result         = '0;
    unique case (phase)
      PH_SYNC: begin
        if (rx_byte == SYNC_SECOND) begin
          phase_next     = PH_LEN;
          field_idx_next = 2'd0;
          declared_next  = 32'd0;
        end else if (rx_byte != SYNC_FIRST) begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN: begin
        declared_next = len_full;
        if (field_idx != 2'd3) begin
          field_idx_next = field_idx + 2'd1;
        end else begin
          field_idx_next = 2'd0;
          if (len_full > {{(32-LIMIT_BITS){1'b0}}, max_len} || len_full > COUNT_MASK) begin
            result.valid        = 1'b1;
            result.is_last      = 1'b1;
            result.status       = ST_OVERSIZE;
            result.frame_length = len_full;
            phase_next          = PH_HUNT;
            crc_next            = CRC_INIT;
          end else begin
            crc_next       = CRC_INIT;
            remaining_next = len_full[LENGTH_BITS-1:0];
            phase_next     = (len_full[LENGTH_BITS-1:0] == '0) ? PH_TRL_LO : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc_next         = crc16_byte(crc, rx_byte);
        remaining_next   = rem_dec;
        if (rem_dec == '0) begin
          phase_next = PH_TRL_LO;
        end
        result.valid     = 1'b1;
        result.data_byte = rx_byte;
        result.status    = ST_PAYLOAD;
      end
      PH_TRL_LO: begin
        trl_lo_next = rx_byte;
        phase_next  = PH_TRL_HI;
      end
      PH_TRL_HI: begin
        result.valid        = 1'b1;
        result.is_last      = 1'b1;
        result.status       = (rx_crc == crc) ? ST_CRC_GOOD : ST_CRC_BAD;
        result.frame_length = declared;
        result.computed_crc = crc;
        result.received_crc = rx_crc;
        phase_next          = PH_HUNT;
        field_idx_next      = 2'd0;
        crc_next            = CRC_INIT;
      end
      default: begin
        phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      field_idx <= 2'd0;
      declared  <= 32'd0;
      remaining <= '0;
      crc       <= CRC_INIT;
      trl_lo    <= 8'd0;
    end else if (step) begin
      phase     <= phase_next;
      field_idx <= field_idx_next;
      declared  <= declared_next;
      remaining <= remaining_next;
      crc       <= crc_next;
      trl_lo    <= trl_lo_next;
    end
  end

endmodule
